// ===== hw/rtl/ppu_pkg.sv =====
// Shared types, format codes and component scaling functions for the packed pixel unpacker.
package ppu_pkg;

	localparam int unsigned FMT_W  = 4;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CH_W   = 8;

	localparam logic [2:0] MAX3  = 3'd7;
	localparam logic [4:0] MAX5  = 5'd31;
	localparam logic [9:0] MAX10 = 10'd1023;

	typedef enum logic [FMT_W-1:0] {
		FMT_332          = 4'd0,
		FMT_233_REV      = 4'd1,
		FMT_565          = 4'd2,
		FMT_565_REV      = 4'd3,
		FMT_4444         = 4'd4,
		FMT_4444_REV     = 4'd5,
		FMT_5551         = 4'd6,
		FMT_1555_REV     = 4'd7,
		FMT_8888         = 4'd8,
		FMT_8888_REV     = 4'd9,
		FMT_10_10_10_2   = 4'd10,
		FMT_2_10_10_10_R = 4'd11
	} fmt_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] a;
	} rgba_t;

	// floor(c*255/max) for each component width
	function automatic logic [7:0] exp1(input logic c);
		return {8{c}};
	endfunction

	function automatic logic [7:0] exp2(input logic [1:0] c);
		return {4{c}};
	endfunction

	function automatic logic [7:0] exp4(input logic [3:0] c);
		return {2{c}};
	endfunction

	// 36c + floor(3c/7)
	function automatic logic [7:0] exp3(input logic [2:0] c);
		logic [4:0] y;
		logic [3:0] r;
		logic [7:0] base;
		y    = {1'b0, c, 1'b0} + {2'b00, c};
		r    = {1'b0, y[2:0]} + {2'b00, y[4:3]};
		base = {c, 5'b0} + {3'b000, c, 2'b00};
		return base + {6'b0, y[4:3]} + {7'b0, (r >= {1'b0, MAX3})};
	endfunction

	// 8c + floor(7c/31)
	function automatic logic [7:0] exp5(input logic [4:0] c);
		logic [7:0] y;
		logic [5:0] r;
		y = {c, 3'b000} - {3'b000, c};
		r = {1'b0, y[4:0]} + {3'b000, y[7:5]};
		return {c, 3'b000} + {5'b0, y[7:5]} + {7'b0, (r >= {1'b0, MAX5})};
	endfunction

	// 4c + floor(c/21)
	function automatic logic [7:0] exp6(input logic [5:0] c);
		logic [1:0] q;
		if (c >= 6'd63)
			q = 2'd3;
		else if (c >= 6'd42)
			q = 2'd2;
		else if (c >= 6'd21)
			q = 2'd1;
		else
			q = 2'd0;
		return {c, 2'b00} + {6'b0, q};
	endfunction

	// floor(x/1023) with x = 255c: x>>10 plus one correction step
	function automatic logic [7:0] exp10(input logic [9:0] c);
		logic [17:0] x;
		logic [7:0]  q0;
		logic [10:0] r;
		x  = {c, 8'b0} - {8'b0, c};
		q0 = x[17:10];
		r  = {1'b0, x[9:0]} + {3'b000, q0};
		return q0 + {7'b0, (r >= {1'b0, MAX10})};
	endfunction

endpackage

// ===== hw/rtl/packed_pixel_unpack_rgba8_unit.sv =====
// Top level of the packed pixel unpacker: format register, input and result registers.
//
// Usage:
//   Input channel: in_valid / in_stall / packed_word. A request is taken at a
//   rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall / red_out, green_out, blue_out,
//   alpha_out. One result request per input request, in order.
//   Format register: cfg_wr_en / cfg_wr_data, written at a rising edge with
//   cfg_wr_en high; change it only while no request is in flight.
//   Path: input register, then unpack and scale logic into the result
//   register. Throughput: 1 request per cycle while out_stall is low;
//   the two registers advance together whenever the result register is
//   empty or being taken.
//   Stall: when out_stall holds a valid result, the input register holds too
//   and in_stall rises once it is occupied; nothing is dropped.
//   Reset: arst_n clears both valid flags and the format register (3_3_2);
//   in_stall is low and out_valid low right after reset.
module packed_pixel_unpack_rgba8_unit
	import ppu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [FMT_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [WORD_W-1:0] packed_word,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CH_W-1:0]   red_out,
	output logic [CH_W-1:0]   green_out,
	output logic [CH_W-1:0]   blue_out,
	output logic [CH_W-1:0]   alpha_out
);

	logic [FMT_W-1:0]  fmt_q;
	logic              vld_s1;
	logic [WORD_W-1:0] word_s1;
	logic              vld_s2;
	rgba_t             pix_s2;
	rgba_t             pix_d;
	logic              adv;
	logic              take;

	assign adv      = !vld_s2 || !out_stall;
	assign in_stall = vld_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_332;
		end else if (cfg_wr_en) begin
			fmt_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				vld_s1 <= take;
			if (adv)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			word_s1 <= packed_word;
		if (adv && vld_s1)
			pix_s2 <= pix_d;
	end

	ppu_unpack u_unpack (
		.fmt  (fmt_q),
		.word (word_s1),
		.pix  (pix_d)
	);

	assign out_valid = vld_s2;
	assign red_out   = pix_s2.r;
	assign green_out = pix_s2.g;
	assign blue_out  = pix_s2.b;
	assign alpha_out = pix_s2.a;

endmodule

// ===== hw/rtl/ppu_unpack.sv =====
// Field extraction and 8-bit scaling of one packed pixel for the selected format.
module ppu_unpack
	import ppu_pkg::*;
(
	input  logic [FMT_W-1:0]  fmt,
	input  logic [WORD_W-1:0] word,
	output rgba_t             pix
);

	always_comb begin
		pix = '0;
		unique case (fmt)
			FMT_332: begin
				pix.r = exp3(word[7:5]);
				pix.g = exp3(word[4:2]);
				pix.b = exp2(word[1:0]);
			end
			FMT_233_REV: begin
				pix.r = exp3(word[2:0]);
				pix.g = exp3(word[5:3]);
				pix.b = exp2(word[7:6]);
			end
			FMT_565: begin
				pix.r = exp5(word[15:11]);
				pix.g = exp6(word[10:5]);
				pix.b = exp5(word[4:0]);
			end
			FMT_565_REV: begin
				pix.r = exp5(word[4:0]);
				pix.g = exp6(word[10:5]);
				pix.b = exp5(word[15:11]);
			end
			FMT_4444: begin
				pix.r = exp4(word[15:12]);
				pix.g = exp4(word[11:8]);
				pix.b = exp4(word[7:4]);
				pix.a = exp4(word[3:0]);
			end
			FMT_4444_REV: begin
				pix.r = exp4(word[3:0]);
				pix.g = exp4(word[7:4]);
				pix.b = exp4(word[11:8]);
				pix.a = exp4(word[15:12]);
			end
			FMT_5551: begin
				pix.r = exp5(word[15:11]);
				pix.g = exp5(word[10:6]);
				pix.b = exp5(word[5:1]);
				pix.a = exp1(word[0]);
			end
			FMT_1555_REV: begin
				pix.r = exp5(word[4:0]);
				pix.g = exp5(word[9:5]);
				pix.b = exp5(word[14:10]);
				pix.a = exp1(word[15]);
			end
			FMT_8888: begin
				pix.r = word[31:24];
				pix.g = word[23:16];
				pix.b = word[15:8];
				pix.a = word[7:0];
			end
			FMT_8888_REV: begin
				pix.r = word[7:0];
				pix.g = word[15:8];
				pix.b = word[23:16];
				pix.a = word[31:24];
			end
			FMT_10_10_10_2: begin
				pix.r = exp10(word[31:22]);
				pix.g = exp10(word[21:12]);
				pix.b = exp10(word[11:2]);
				pix.a = exp2(word[1:0]);
			end
			FMT_2_10_10_10_R: begin
				pix.r = exp10(word[9:0]);
				pix.g = exp10(word[19:10]);
				pix.b = exp10(word[29:20]);
				pix.a = exp2(word[31:30]);
			end
			default: begin
				pix = '0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ppu_checker.sv =====
// Port-level checker for the packed pixel unpacker, bound to the top level.
module ppu_checker
	import ppu_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [CH_W-1:0]   red_out,
	input logic [CH_W-1:0]   green_out,
	input logic [CH_W-1:0]   blue_out,
	input logic [CH_W-1:0]   alpha_out
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(green_out)
			&& $stable(blue_out) && $stable(alpha_out))
		else $error("stalled result changed");

	// a free output side never backs up the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled while output free");

	// accepted request reaches the output if the output side is free after acceptance
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
		else $error("result missing after two cycles");

	// quiet ports once a reset edge has been seen
	a_reset: assert property (@(posedge clk) !arst_n |=> !out_valid && !in_stall)
		else $error("activity during reset");

endmodule

bind packed_pixel_unpack_rgba8_unit ppu_checker u_ppu_checker (.*);
